[hw/rtl/spq_pkg.sv]
package spq_pkg;

    localparam int DEPTH     = 16;
    localparam int DATA_BITS = 8;
    localparam int PRIO_BITS = 8;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    // tdata layouts
    localparam int IN_BITS   = DATA_BITS + PRIO_BITS;
    localparam int IN_BYTES  = (IN_BITS + 7) / 8;
    localparam int OUT_BITS  = DATA_BITS + 2 + DATA_BITS + 1 + CNT_BITS;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

[hw/rtl/stable_priority_queue.sv]
// Channel   Dir  Handshake           Contents
// s_*       in   s_tvalid/s_tready   tdata: item_data, item_priority; tuser: mode
// m_*       out  m_tvalid/m_tready   tdata: popped_data, status, front_data,
//                                           front_valid, entry_count
//
// Each word is captured into the input registers, then executed: every slot
// compares against the new priority at once and the row shifts in place.
// A word is taken again in the cycle after the result is registered, so a
// new word is not accepted until the last one has executed.
// A stalled output holds the result; the next word is captured meanwhile and
// waits to execute until the output register frees. Reset empties the queue.
module stable_priority_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] item_data, [15:8] item_priority
    input  logic [spq_pkg::IN_BYTES*8-1:0]      s_tdata,
    // [0] mode
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] popped_data, [9:8] status, [17:10] front_data, [18] front_valid,
    // [23:19] entry_count
    output logic [spq_pkg::OUT_BYTES*8-1:0]     m_tdata
);

    spq_pkg::cmd_t cmd;

    spq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    spq_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .in_mode (s_tuser),
        .in_data (s_tdata[spq_pkg::DATA_BITS-1:0]),
        .in_prio (s_tdata[spq_pkg::IN_BITS-1:spq_pkg::DATA_BITS]),
        .result  (m_tdata)
    );

endmodule

[hw/rtl/spq_ctrl.sv]
module spq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output spq_pkg::cmd_t cmd
);

    spq_pkg::state_t state_reg;
    spq_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        s_tready       = 1'b0;
        cmd            = '0;

        // the word in the output register leaves on its handshake
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            spq_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = spq_pkg::S_EXEC;
                end
            end
            spq_pkg::S_EXEC:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = spq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::S_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

[hw/rtl/spq_datapath.sv]
module spq_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  spq_pkg::cmd_t                       cmd,
    input  logic                                in_mode,
    input  logic [spq_pkg::DATA_BITS-1:0]       in_data,
    input  logic [spq_pkg::PRIO_BITS-1:0]       in_prio,
    output logic [spq_pkg::OUT_BYTES*8-1:0]     result
);

    localparam int D = spq_pkg::DEPTH;

    logic                          mode_reg;
    logic [spq_pkg::DATA_BITS-1:0] data_reg;
    logic [spq_pkg::PRIO_BITS-1:0] prio_reg;

    logic [spq_pkg::DATA_BITS-1:0] slot_data_reg [D];
    logic [spq_pkg::PRIO_BITS-1:0] slot_prio_reg [D];
    logic [spq_pkg::DATA_BITS-1:0] slot_data_next [D];
    logic [spq_pkg::PRIO_BITS-1:0] slot_prio_next [D];

    logic [spq_pkg::CNT_BITS-1:0]  fill_reg;
    logic [spq_pkg::CNT_BITS-1:0]  fill_next;

    logic [spq_pkg::DATA_BITS-1:0] popped_reg;
    logic [spq_pkg::DATA_BITS-1:0] popped_next;
    spq_pkg::status_t              status_reg;
    spq_pkg::status_t              status_next;
    logic [spq_pkg::DATA_BITS-1:0] front_reg;
    logic [spq_pkg::DATA_BITS-1:0] front_next;
    logic                          fvalid_reg;
    logic [spq_pkg::CNT_BITS-1:0]  count_reg;

    logic [D-1:0] le;
    logic [D-1:0] le_prev;
    logic         full;
    logic         empty;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_mode;
            data_reg <= in_data;
            prio_reg <= in_prio;
        end
    end

    // each slot compares against the new priority in parallel
    always_comb
    begin
        for (int i = 0; i < D; i++)
        begin
            le[i] = (spq_pkg::CNT_BITS'(i) < fill_reg) && (slot_prio_reg[i] <= prio_reg);
        end
    end

    assign le_prev = {le[D-2:0], 1'b1};
    assign full    = (fill_reg == spq_pkg::CNT_BITS'(D));
    assign empty   = (fill_reg == '0);

    always_comb
    begin
        for (int i = 0; i < D; i++)
        begin
            slot_data_next[i] = slot_data_reg[i];
            slot_prio_next[i] = slot_prio_reg[i];
        end
        fill_next   = fill_reg;
        popped_next = '0;
        status_next = spq_pkg::ST_OK;

        if (mode_reg == spq_pkg::MODE_PUSH)
        begin
            if (full)
            begin
                status_next = spq_pkg::ST_FULL;
            end
            else
            begin
                // keep slots ahead, drop the new word at the first slot behind, shift the rest
                if (!le[0])
                begin
                    slot_data_next[0] = data_reg;
                    slot_prio_next[0] = prio_reg;
                end
                for (int i = 1; i < D; i++)
                begin
                    if (!le[i])
                    begin
                        if (le_prev[i])
                        begin
                            slot_data_next[i] = data_reg;
                            slot_prio_next[i] = prio_reg;
                        end
                        else
                        begin
                            slot_data_next[i] = slot_data_reg[i-1];
                            slot_prio_next[i] = slot_prio_reg[i-1];
                        end
                    end
                end
                fill_next = fill_reg + 1'b1;
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = spq_pkg::ST_EMPTY;
            end
            else
            begin
                popped_next = slot_data_reg[0];
                for (int i = 0; i < D - 1; i++)
                begin
                    slot_data_next[i] = slot_data_reg[i+1];
                    slot_prio_next[i] = slot_prio_reg[i+1];
                end
                fill_next = fill_reg - 1'b1;
            end
        end

        front_next = (fill_next != '0) ? slot_data_next[0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (cmd.exec)
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            for (int i = 0; i < D; i++)
            begin
                slot_data_reg[i] <= slot_data_next[i];
                slot_prio_reg[i] <= slot_prio_next[i];
            end
            popped_reg <= popped_next;
            status_reg <= status_next;
            front_reg  <= front_next;
            fvalid_reg <= (fill_next != '0);
            count_reg  <= fill_next;
        end
    end

    assign result = {{(spq_pkg::OUT_BYTES*8 - spq_pkg::OUT_BITS){1'b0}},
                     count_reg, fvalid_reg, front_reg, status_reg, popped_reg};

endmodule

[tb/tb.sv]
module tb;
    import spq_pkg::*;

    localparam int RANDOM_WORDS = 1900;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SHOW_LIMIT   = 10;
    localparam int TAIL_CYCLES  = 10;

    // same bit order as m_tdata, popped_data in the lowest bits
    typedef struct packed {
        logic [CNT_BITS-1:0]  count;
        logic                 fvalid;
        logic [DATA_BITS-1:0] front;
        status_t              status;
        logic [DATA_BITS-1:0] popped;
    } qres_t;

    typedef struct {
        logic                 mode;
        logic [DATA_BITS-1:0] data;
        logic [PRIO_BITS-1:0] prio;
        bit                   typed;
        qres_t                want;
    } dir_row_t;

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_BYTES*8-1:0]   s_tdata  = '0;
    logic                    s_tuser  = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_BYTES*8-1:0]  m_tdata;

    // shadow copy of the sorted store
    logic [DATA_BITS-1:0] model_data [DEPTH];
    logic [PRIO_BITS-1:0] model_prio [DEPTH];
    int                   model_fill = 0;

    qres_t    pending_results [$];
    dir_row_t dir_rows [$];

    int n_push    = 0;
    int n_pop     = 0;
    int n_full    = 0;
    int n_empty   = 0;
    int peak_fill = 0;
    int n_checked = 0;
    int n_bad     = 0;
    int cycles    = 0;
    bit rx_calm   = 1'b0;
    int rx_hold   = 0;

    stable_priority_queue u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // output back-pressure: mostly short stalls, now and then a long one
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_tready <= 1'b0;
        end
        else if (!rx_calm && $urandom_range(0, 99) < 20)
        begin
            rx_hold = ($urandom_range(0, 9) == 0) ? int'($urandom_range(8, 40))
                                                  : int'($urandom_range(0, 2));
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        qres_t got;
        qres_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = qres_t'(m_tdata[OUT_BITS-1:0]);
            if (pending_results.size() == 0)
            begin
                n_bad++;
                if (n_bad <= SHOW_LIMIT)
                    $display("result word %h arrived with nothing expected", m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                n_checked++;
                if (got.popped !== want.popped || got.status !== want.status ||
                    got.front !== want.front || got.fvalid !== want.fvalid ||
                    got.count !== want.count)
                begin
                    n_bad++;
                    if (n_bad <= SHOW_LIMIT)
                    begin
                        $write("mismatch on word %0d: popped %h/%h status %0d/%0d ",
                               n_checked, want.popped, got.popped, want.status,
                               got.status);
                        $display("front %h/%h valid %b/%b count %0d/%0d (want/got)",
                                 want.front, got.front, want.fvalid, got.fvalid,
                                 want.count, got.count);
                    end
                end
            end
        end
    end

    function automatic qres_t predict_queue_word(input logic mode,
                                                 input logic [DATA_BITS-1:0] data,
                                                 input logic [PRIO_BITS-1:0] prio);
        qres_t r;
        int    pos;
        r        = '0;
        r.status = ST_OK;
        if (mode == MODE_PUSH)
        begin
            n_push++;
            if (model_fill >= DEPTH)
            begin
                r.status = ST_FULL;
                n_full++;
            end
            else
            begin
                // go behind every entry of lower or equal priority
                pos = 0;
                while (pos < model_fill && model_prio[pos] <= prio)
                    pos++;
                for (int i = model_fill; i > pos; i--)
                begin
                    model_data[i] = model_data[i-1];
                    model_prio[i] = model_prio[i-1];
                end
                model_data[pos] = data;
                model_prio[pos] = prio;
                model_fill++;
                if (model_fill > peak_fill)
                    peak_fill = model_fill;
            end
        end
        else
        begin
            n_pop++;
            if (model_fill == 0)
            begin
                r.status = ST_EMPTY;
                n_empty++;
            end
            else
            begin
                r.popped = model_data[0];
                for (int i = 1; i < model_fill; i++)
                begin
                    model_data[i-1] = model_data[i];
                    model_prio[i-1] = model_prio[i];
                end
                model_fill--;
            end
        end
        r.fvalid = (model_fill > 0);
        r.front  = (model_fill > 0) ? model_data[0] : '0;
        r.count  = CNT_BITS'(model_fill);
        return r;
    endfunction

    task automatic add_row(input logic mode, input logic [DATA_BITS-1:0] data,
                           input logic [PRIO_BITS-1:0] prio, input bit typed,
                           input qres_t want);
        dir_row_t row;
        row.mode  = mode;
        row.data  = data;
        row.prio  = prio;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    // hold the word on the bus until taken; valid stays high for the caller
    task automatic send_word(input logic mode, input logic [DATA_BITS-1:0] data,
                             input logic [PRIO_BITS-1:0] prio, input bit typed,
                             input qres_t want);
        qres_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {prio, data};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = predict_queue_word(mode, data, prio);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic sender_pause(input bit calm);
        int r;
        int gap;
        r = int'($urandom_range(0, 99));
        if (calm || r < 65)
            gap = 0;
        else if (r < 93)
            gap = int'($urandom_range(1, 3));
        else
            gap = int'($urandom_range(6, 30));
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int                   done;
        int                   run_len;
        int                   push_pct;
        bit                   narrow;
        bit                   tx_calm;
        bit                   pressed;
        logic                 mode;
        logic [DATA_BITS-1:0] data;
        logic [PRIO_BITS-1:0] prio;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(MODE_POP, 8'h00, 8'h00, 1'b1,
                '{popped: 8'h00, status: ST_EMPTY, front: 8'h00, fvalid: 1'b0, count: 5'd0});
        add_row(MODE_PUSH, 8'hff, 8'hff, 1'b1,
                '{popped: 8'h00, status: ST_OK, front: 8'hff, fvalid: 1'b1, count: 5'd1});
        add_row(MODE_PUSH, 8'h00, 8'h00, 1'b1,
                '{popped: 8'h00, status: ST_OK, front: 8'h00, fvalid: 1'b1, count: 5'd2});
        // ties at 0x80 must leave in arrival order
        add_row(MODE_PUSH, 8'h5a, 8'h80, 1'b0, '0);
        add_row(MODE_PUSH, 8'ha5, 8'h80, 1'b0, '0);
        add_row(MODE_PUSH, 8'h3c, 8'h80, 1'b0, '0);
        add_row(MODE_PUSH, 8'h01, 8'h7f, 1'b0, '0);
        add_row(MODE_PUSH, 8'h80, 8'h01, 1'b0, '0);
        add_row(MODE_PUSH, 8'h7e, 8'h00, 1'b0, '0);
        add_row(MODE_PUSH, 8'hc3, 8'hff, 1'b0, '0);
        add_row(MODE_PUSH, 8'h11, 8'h40, 1'b0, '0);
        add_row(MODE_PUSH, 8'h22, 8'hc0, 1'b0, '0);
        add_row(MODE_PUSH, 8'h33, 8'h80, 1'b0, '0);
        add_row(MODE_PUSH, 8'h44, 8'hfe, 1'b0, '0);
        add_row(MODE_PUSH, 8'h55, 8'h02, 1'b0, '0);
        add_row(MODE_PUSH, 8'h66, 8'h80, 1'b0, '0);
        add_row(MODE_PUSH, 8'h77, 8'h80, 1'b0, '0);
        // queue is full now: drop this one
        add_row(MODE_PUSH, 8'haa, 8'h00, 1'b1,
                '{popped: 8'h00, status: ST_FULL, front: 8'h00, fvalid: 1'b1, count: 5'd16});
        add_row(MODE_POP, 8'hff, 8'hff, 1'b1,
                '{popped: 8'h00, status: ST_OK, front: 8'h7e, fvalid: 1'b1, count: 5'd15});
        add_row(MODE_POP, 8'h55, 8'haa, 1'b0, '0);
        add_row(MODE_POP, 8'h00, 8'h00, 1'b0, '0);
        add_row(MODE_POP, 8'hff, 8'h00, 1'b0, '0);

        foreach (dir_rows[i])
        begin
            send_word(dir_rows[i].mode, dir_rows[i].data, dir_rows[i].prio,
                      dir_rows[i].typed, dir_rows[i].want);
            sender_pause(1'b0);
        end
        drain_results();

        // runs with a push bias each, so the queue swings between empty and full
        done    = 0;
        pressed = 1'b0;
        while (done < RANDOM_WORDS)
        begin
            run_len = int'($urandom_range(40, 160));
            case ($urandom_range(0, 3))
                0:       push_pct = 15;
                1:       push_pct = 50;
                2:       push_pct = 85;
                default: push_pct = 97;
            endcase
            narrow  = ($urandom_range(0, 2) != 0);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < run_len && done < RANDOM_WORDS; k++)
            begin
                if (!pressed && done >= RANDOM_WORDS / 2)
                begin
                    drain_results();
                    pressed = 1'b1;
                end
                mode = (int'($urandom_range(0, 99)) < push_pct) ? MODE_PUSH : MODE_POP;
                data = DATA_BITS'($urandom);
                prio = narrow ? PRIO_BITS'($urandom_range(0, 3)) : PRIO_BITS'($urandom);
                send_word(mode, data, prio, 1'b0, '0);
                done++;
                sender_pause(tx_calm);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Queue run: %0d result words checked, %0d pushes, %0d pops, peak fill %0d of %0d",
                 n_checked, n_push, n_pop, peak_fill, DEPTH);
        $display("Boundaries: %0d pushes refused on a full queue, %0d pops on an empty queue",
                 n_full, n_empty);
        if (n_bad == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
